// ----- rtl/core/tsq_pkg.sv -----
// Shared types and operation codes for the two-stack queue.
package tsq_pkg;

  typedef enum logic [1:0] {
    KIND_PUSH = 2'd0,
    KIND_POP  = 2'd1,
    KIND_READ = 2'd2,
    KIND_BAD  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_XFER,
    ST_RDWAIT
  } state_e;

  localparam int unsigned CAP_W   = 5;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned POS_W   = 5;
  localparam int unsigned COUNT_W = 6;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

endpackage

// ----- rtl/core/tsq_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
module tsq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ----- rtl/core/two_stack_queue_core.sv -----
// Top level of the two-stack queue: command FSM, stack counters and two stack RAMs.
// Flow: an accepted item is held and decided in DECIDE. A push that fits, or any item that errors,
// registers its result there and strobes done_o; a pop or read first passes RDWAIT for the RAM read.
// When the inbox must first be moved to the outbox, XFER copies one element per cycle through the
// RAM ports, then DECIDE runs again. busy is low while done_o strobes, so the next item can be taken then.
// Reset clears the counters and sets the capacity to 16; stack contents are not cleared.
module two_stack_queue_core #(
  parameter int unsigned STACK_DEPTH = 16,
  parameter int unsigned DATA_WIDTH  = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         kind_i,
  input  logic signed [tsq_pkg::VALUE_W-1:0] push_value_i,
  input  logic [tsq_pkg::POS_W-1:0]          position_i,
  input  logic                               cfg_we_i,
  input  logic [tsq_pkg::CAP_W-1:0]          cfg_wdata_i,
  output logic                               done_o,
  output logic signed [tsq_pkg::VALUE_W-1:0] read_data_o,
  output logic                               error_o,
  output logic [tsq_pkg::COUNT_W-1:0]        element_count_o,
  output logic                               is_full_o
);

  import tsq_pkg::*;

  localparam int unsigned AW    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);

  state_e state_q, state_d;
  kind_e  kind_q;
  logic [DATA_WIDTH-1:0] pv_q;
  logic [POS_W-1:0]      pos_q;
  logic [CAP_W-1:0]      cap_q;
  logic [CNT_W-1:0]      in_cnt_q, in_cnt_d;
  logic [CNT_W-1:0]      out_cnt_q, out_cnt_d;
  logic                  pend_q, pend_d;
  logic                  sel_ob_q, sel_ob_d;
  logic                  res_valid_q, res_valid_d;
  logic                  res_err_q, res_err_d;
  logic [DATA_WIDTH-1:0] res_data_q, res_data_d;

  logic [CNT_W-1:0]  cap_eff;
  logic [CNT_W:0]    total;
  logic              do_push, do_xfer, do_read, do_err;
  logic              read_ob;
  logic [31:0]       ob_idx, ib_idx;

  logic                  ib_we, ob_we;
  logic [AW-1:0]         ib_waddr, ib_raddr, ob_waddr, ob_raddr;
  logic [DATA_WIDTH-1:0] ib_wdata, ib_rdata, ob_rdata;
  logic [DATA_WIDTH+VALUE_W-1:0] pv_ext, rd_ext;

  // Capacity zero acts as one; anything above the RAM depth acts as the depth.
  always_comb begin
    if (cap_q == '0) begin
      cap_eff = CNT_W'(1);
    end else if (32'(cap_q) > 32'(STACK_DEPTH)) begin
      cap_eff = CNT_W'(STACK_DEPTH);
    end else begin
      cap_eff = CNT_W'(cap_q);
    end
  end

  assign total  = {1'b0, in_cnt_q} + {1'b0, out_cnt_q};
  assign ob_idx = 32'(out_cnt_q) - 32'd1 - ((kind_q == KIND_READ) ? 32'(pos_q) : 32'd0);
  assign ib_idx = 32'(pos_q) - 32'(out_cnt_q);

  // Decision taken in the DECIDE state for the held item.
  always_comb begin
    do_push = 1'b0;
    do_xfer = 1'b0;
    do_read = 1'b0;
    do_err  = 1'b0;
    read_ob = 1'b0;
    case (kind_q)
      KIND_PUSH: begin
        if (in_cnt_q < cap_eff) begin
          do_push = 1'b1;
        end else if (out_cnt_q == '0) begin
          do_xfer = 1'b1;
        end else begin
          do_err = 1'b1;
        end
      end
      KIND_POP: begin
        if (total == '0) begin
          do_err = 1'b1;
        end else if (out_cnt_q == '0) begin
          do_xfer = 1'b1;
        end else begin
          do_read = 1'b1;
          read_ob = 1'b1;
        end
      end
      KIND_READ: begin
        if (32'(pos_q) >= 32'(total)) begin
          do_err = 1'b1;
        end else begin
          do_read = 1'b1;
          read_ob = (32'(pos_q) < 32'(out_cnt_q));
        end
      end
      default: begin
        do_err = 1'b1;
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (do_xfer) begin
          state_d = ST_XFER;
        end else if (do_read) begin
          state_d = ST_RDWAIT;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_XFER: begin
        // Re-decide once the last moved element has been written.
        if (in_cnt_q == '0 && !pend_q) begin
          state_d = ST_DECIDE;
        end
      end
      ST_RDWAIT: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign pv_ext = {{DATA_WIDTH{1'b0}}, push_value_i};

  // Datapath and RAM control.
  always_comb begin
    in_cnt_d    = in_cnt_q;
    out_cnt_d   = out_cnt_q;
    pend_d      = 1'b0;
    sel_ob_d    = sel_ob_q;
    res_valid_d = 1'b0;
    res_err_d   = res_err_q;
    res_data_d  = res_data_q;
    ib_we       = 1'b0;
    ib_waddr    = AW'(in_cnt_q);
    ib_wdata    = pv_q;
    ib_raddr    = AW'(ib_idx);
    ob_we       = 1'b0;
    ob_waddr    = AW'(out_cnt_q);
    ob_raddr    = AW'(ob_idx);
    case (state_q)
      ST_DECIDE: begin
        if (do_push) begin
          ib_we       = 1'b1;
          in_cnt_d    = in_cnt_q + CNT_W'(1);
          res_valid_d = 1'b1;
          res_err_d   = 1'b0;
          res_data_d  = '0;
        end else if (do_err) begin
          res_valid_d = 1'b1;
          res_err_d   = 1'b1;
          res_data_d  = '0;
        end else if (do_read) begin
          sel_ob_d = read_ob;
          if (kind_q == KIND_POP) begin
            out_cnt_d = out_cnt_q - CNT_W'(1);
          end
        end
      end
      ST_XFER: begin
        // Read the inbox top now; write it to the outbox in the cycle after, once the RAM read is registered.
        ib_raddr = AW'(in_cnt_q - CNT_W'(1));
        if (in_cnt_q != '0) begin
          in_cnt_d = in_cnt_q - CNT_W'(1);
          pend_d   = 1'b1;
        end
        if (pend_q) begin
          ob_we     = 1'b1;
          out_cnt_d = out_cnt_q + CNT_W'(1);
        end
      end
      ST_RDWAIT: begin
        res_valid_d = 1'b1;
        res_err_d   = 1'b0;
        res_data_d  = sel_ob_q ? ob_rdata : ib_rdata;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cap_q       <= CAP_RESET;
      in_cnt_q    <= '0;
      out_cnt_q   <= '0;
      pend_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      in_cnt_q    <= in_cnt_d;
      out_cnt_q   <= out_cnt_d;
      pend_q      <= pend_d;
      res_valid_q <= res_valid_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start) begin
      kind_q <= kind_e'(kind_i);
      pv_q   <= pv_ext[DATA_WIDTH-1:0];
      pos_q  <= position_i;
    end
    sel_ob_q   <= sel_ob_d;
    res_err_q  <= res_err_d;
    res_data_q <= res_data_d;
  end

  tsq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (STACK_DEPTH)
  ) u_inbox_ram (
    .clk_i   (clk_i),
    .we_i    (ib_we),
    .waddr_i (ib_waddr),
    .wdata_i (ib_wdata),
    .raddr_i (ib_raddr),
    .rdata_o (ib_rdata)
  );

  tsq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (STACK_DEPTH)
  ) u_outbox_ram (
    .clk_i   (clk_i),
    .we_i    (ob_we),
    .waddr_i (ob_waddr),
    .wdata_i (ib_rdata),
    .raddr_i (ob_raddr),
    .rdata_o (ob_rdata)
  );

  assign rd_ext          = {{VALUE_W{1'b0}}, res_data_q};
  assign busy            = (state_q != ST_IDLE);
  assign done_o          = res_valid_q;
  assign read_data_o     = rd_ext[VALUE_W-1:0];
  assign error_o         = res_err_q;
  assign element_count_o = COUNT_W'(total);
  assign is_full_o       = (in_cnt_q >= cap_eff) && (out_cnt_q != '0);

  a_done_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(state_q) == ST_DECIDE || $past(state_q) == ST_RDWAIT))
    else $error("result strobe without a deciding or read state before it");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(in_cnt_q) <= 32'(STACK_DEPTH)) && (32'(out_cnt_q) <= 32'(STACK_DEPTH)))
    else $error("stack count above depth");

  a_ob_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ob_we |-> (32'(out_cnt_q) < 32'(STACK_DEPTH)))
    else $error("outbox write with no room");

  a_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (state_q == ST_DECIDE))
    else $error("accepted item not decided next cycle");

  a_err_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && error_o) |->
      (in_cnt_q == $past(in_cnt_q) && out_cnt_q == $past(out_cnt_q)))
    else $error("erroring item changed the stacks");

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for the two-stack queue core: directed and random items.
`timescale 1ns / 1ps

module tb;
  import tsq_pkg::*;

  localparam int unsigned DEPTH = 16;

  typedef struct packed {
    logic [VALUE_W-1:0] data;
    logic               error;
    logic [COUNT_W-1:0] count;
    logic               full;
  } qresult_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         kind_i = '0;
  logic [VALUE_W-1:0] push_value_i = '0;
  logic [POS_W-1:0]   position_i = '0;
  logic               cfg_we_i = 1'b0;
  logic [CAP_W-1:0]   cfg_wdata_i = '0;
  logic               done_o;
  logic [VALUE_W-1:0] read_data_o;
  logic               error_o;
  logic [COUNT_W-1:0] element_count_o;
  logic               is_full_o;

  // Predicted queue state.
  logic [VALUE_W-1:0] inbox_mem [DEPTH];
  logic [VALUE_W-1:0] outbox_mem [DEPTH];
  int unsigned        inbox_n;
  int unsigned        outbox_n;
  logic [CAP_W-1:0]   capacity_reg;

  qresult_t    pending_results[$];
  int unsigned mismatch_count = 0;
  int unsigned burst_left = 0;

  two_stack_queue_core DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .kind_i         (kind_i),
    .push_value_i   (push_value_i),
    .position_i     (position_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .done_o         (done_o),
    .read_data_o    (read_data_o),
    .error_o        (error_o),
    .element_count_o(element_count_o),
    .is_full_o      (is_full_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic int unsigned effective_capacity();
    int unsigned c;
    c = capacity_reg;
    if (c < 1) c = 1;
    if (c > DEPTH) c = DEPTH;
    return c;
  endfunction

  // Moves the whole inbox onto the outbox; the top of the inbox lands at the bottom.
  function automatic void move_inbox();
    while (inbox_n > 0 && outbox_n < DEPTH) begin
      inbox_n--;
      outbox_mem[outbox_n] = inbox_mem[inbox_n];
      outbox_n++;
    end
  endfunction

  function automatic void queue_model_step(kind_e k, logic [VALUE_W-1:0] v,
                                           logic [POS_W-1:0] pos);
    qresult_t    r;
    int unsigned cap;
    int unsigned total;
    r = '0;
    cap = effective_capacity();
    total = inbox_n + outbox_n;
    case (k)
      KIND_PUSH: begin
        if (inbox_n < cap) begin
          inbox_mem[inbox_n] = v;
          inbox_n++;
        end else if (outbox_n == 0) begin
          move_inbox();
          inbox_mem[0] = v;
          inbox_n = 1;
        end else begin
          r.error = 1'b1;
        end
      end
      KIND_POP: begin
        if (total == 0) begin
          r.error = 1'b1;
        end else begin
          if (outbox_n == 0) move_inbox();
          outbox_n--;
          r.data = outbox_mem[outbox_n];
        end
      end
      KIND_READ: begin
        if (pos >= total) r.error = 1'b1;
        else if (pos < outbox_n) r.data = outbox_mem[outbox_n - 1 - pos];
        else r.data = inbox_mem[pos - outbox_n];
      end
      default: r.error = 1'b1;
    endcase
    r.count = COUNT_W'(inbox_n + outbox_n);
    r.full = (inbox_n >= cap) && (outbox_n != 0);
    pending_results.push_back(r);
  endfunction

  // Offers one item and holds it until the core takes it.
  task automatic issue_item(kind_e k, logic [VALUE_W-1:0] v, logic [POS_W-1:0] pos);
    @(negedge clk_i);
    kind_i = k;
    push_value_i = v;
    position_i = pos;
    start = 1'b1;
    do @(posedge clk_i); while (busy);
    queue_model_step(k, v, pos);
    @(negedge clk_i);
    start = 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] c);
    wait_drained();
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_wdata_i = c;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    capacity_reg = c;
  endtask

  // Sender pacing: bursts of random length separated by random gaps.
  task automatic sender_pause(bit no_gaps);
    int unsigned gap;
    if (no_gaps) return;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = $urandom_range(0, 6);
      repeat (gap) @(negedge clk_i);
    end
    burst_left--;
  endtask

  task automatic test_empty_queue();
    issue_item(KIND_POP, '0, '0);
    issue_item(KIND_READ, '0, 5'd0);
    issue_item(KIND_BAD, 32'hFFFF_FFFF, 5'd31);
    issue_item(KIND_READ, '0, 5'd31);
  endtask

  task automatic test_push_extremes();
    issue_item(KIND_PUSH, 32'h8000_0000, '0);
    issue_item(KIND_PUSH, 32'h7FFF_FFFF, '0);
    issue_item(KIND_PUSH, 32'h0000_0000, '0);
    issue_item(KIND_PUSH, 32'hFFFF_FFFF, '0);
    issue_item(KIND_PUSH, 32'h5A5A_5A5A, 5'd31);
    issue_item(KIND_PUSH, 32'hA5A5_A5A5, '0);
    issue_item(KIND_READ, '0, 5'd0);
    issue_item(KIND_READ, '0, 5'd5);
    issue_item(KIND_READ, '0, 5'd6);
    issue_item(KIND_POP, '0, '0);
  endtask

  // Capacity extremes and a capacity lowered below what the inbox holds.
  task automatic test_capacity_edges();
    write_capacity(5'd1);
    issue_item(KIND_PUSH, 32'h1111_1111, '0);
    issue_item(KIND_PUSH, 32'h2222_2222, '0);
    write_capacity(5'd0);
    issue_item(KIND_PUSH, 32'h3333_3333, '0);
    write_capacity(5'd31);
    issue_item(KIND_PUSH, 32'h4444_4444, '0);
    issue_item(KIND_READ, '0, 5'd5);
    issue_item(KIND_READ, '0, 5'd6);
    write_capacity(5'd1);
    issue_item(KIND_PUSH, 32'h5555_5555, '0);
    issue_item(KIND_POP, '0, '0);
  endtask

  task automatic test_random();
    logic [CAP_W-1:0]   caps[10] = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd2,
                                     5'd5, 5'd10, 5'd16, 5'd3, 5'd31};
    int unsigned        r;
    int unsigned        total;
    bit                 filling;
    kind_e              k;
    logic [VALUE_W-1:0] v;
    logic [POS_W-1:0]   pos;
    filling = 1'b1;
    for (int ph = 0; ph < 10; ph++) begin
      write_capacity(ph < 8 ? caps[ph] : CAP_W'($urandom_range(0, 31)));
      for (int i = 0; i < 115; i++) begin
        total = inbox_n + outbox_n;
        if (total == 0) filling = 1'b1;
        else if (inbox_n >= effective_capacity() && outbox_n != 0) filling = 1'b0;
        else if ($urandom_range(0, 24) == 0) filling = ~filling;
        r = $urandom_range(0, 99);
        if (r < 3) k = KIND_BAD;
        else if (r < 23) k = KIND_READ;
        else if (filling) k = (r < 80) ? KIND_PUSH : KIND_POP;
        else k = (r < 40) ? KIND_PUSH : KIND_POP;
        case ($urandom_range(0, 11))
          0: v = 32'h8000_0000;
          1: v = 32'h7FFF_FFFF;
          2: v = 32'h0000_0000;
          3: v = 32'hFFFF_FFFF;
          default: v = $urandom;
        endcase
        if (total > 0 && $urandom_range(0, 3) != 0) pos = POS_W'($urandom_range(0, total - 1));
        else pos = POS_W'($urandom_range(0, 31));
        sender_pause(ph % 3 == 2);
        issue_item(k, v, pos);
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin : check_result
      qresult_t want;
      if (pending_results.size() == 0) begin
        $error("result with no item pending");
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (read_data_o !== want.data) begin
          $error("read_data: expected %h, got %h", want.data, read_data_o);
          mismatch_count++;
        end
        if (error_o !== want.error) begin
          $error("error: expected %b, got %b", want.error, error_o);
          mismatch_count++;
        end
        if (element_count_o !== want.count) begin
          $error("element_count: expected %0d, got %0d", want.count, element_count_o);
          mismatch_count++;
        end
        if (is_full_o !== want.full) begin
          $error("is_full: expected %b, got %b", want.full, is_full_o);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    inbox_n = 0;
    outbox_n = 0;
    capacity_reg = CAP_RESET;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_empty_queue();
    test_push_extremes();
    test_capacity_edges();
    test_random();
    wait_drained();
    repeat (20) @(posedge clk_i);
    if (pending_results.size() != 0) mismatch_count++;
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
